// ===== src/aesc_pkg.sv =====
package aesc_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int ACC_W      = ANGLE_BITS + 2;   // signed accumulator / delta
    localparam int STEP_W     = ANGLE_BITS + 1;   // step magnitude
    localparam int TIME_W     = 32;
    localparam int IVAL_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(STEP_W + 1);

    localparam logic [ANGLE_BITS-1:0] PPS_RESET  = ANGLE_BITS'(600);
    localparam logic [IVAL_W-1:0]     IVAL_RESET = IVAL_W'(200);

    localparam logic signed [ACC_W-1:0] ANG_HALF = ACC_W'(1 << (ANGLE_BITS - 1));
    localparam logic signed [ACC_W-1:0] ANG_MOD  = ACC_W'(1 << ANGLE_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED      = 2'd0,
        CFG_ZERO_OFFSET  = 2'd1,
        CFG_POS_PER_STEP = 2'd2,
        CFG_MIN_INTERVAL = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_START = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/angle_encoder_step_counter.sv =====
// Input beat to result beat: delta/accumulate, divider load, one divider iteration
// per quotient bit, emit decision, output load, result beat. A new sample is taken
// only in idle, none while the last is in work; a first or unmoved sample returns
// to idle after the delta stage, and a stalled result holds the block in emit.
// Reset (aresetn low, synchronous): disabled, baseline and accumulator cleared,
// zero_offset 0, positions_per_step 600, min_interval_ms 200.
module angle_encoder_step_counter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [aesc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aesc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [aesc_pkg::ANGLE_BITS-1:0]   s_raw_angle,
    input  logic [aesc_pkg::TIME_W-1:0]       s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_direction,
    output logic [aesc_pkg::STEP_W-1:0]       m_step_count
);
    import aesc_pkg::*;

    state_t state_reg, state_next;

    logic                    enabled_reg;
    logic [ANGLE_BITS-1:0]   zero_offset_reg;
    logic [ANGLE_BITS-1:0]   pps_reg;
    logic [IVAL_W-1:0]       min_ival_reg;

    logic [ANGLE_BITS-1:0]   last_pos_reg;
    logic                    have_base_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [TIME_W-1:0]       last_emit_reg;

    logic [ANGLE_BITS-1:0]   raw_reg;
    logic [TIME_W-1:0]       now_reg;

    logic                    m_valid_reg;
    logic                    m_dir_reg;
    logic [STEP_W-1:0]       m_cnt_reg;
    logic                    res_dir_reg;
    logic [STEP_W-1:0]       res_cnt_reg;

    logic                    in_beat;
    logic [ANGLE_BITS-1:0]   pos;
    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] delta;
    logic signed [ACC_W-1:0] acc_neg;
    logic [STEP_W-1:0]       acc_mag;
    logic [ANGLE_BITS-1:0]   divisor;
    logic                    out_free;
    logic                    interval_met;
    logic signed [ACC_W-1:0] rem_signed;

    div_status_t             div_st;
    logic [STEP_W-1:0]       div_quo;
    logic [ANGLE_BITS-1:0]   div_rem;

    assign in_beat = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        pos  = raw_reg - zero_offset_reg;
        diff = $signed({{(ACC_W-ANGLE_BITS){1'b0}}, pos})
             - $signed({{(ACC_W-ANGLE_BITS){1'b0}}, last_pos_reg});
        // shortest path; exactly half a turn stays as is
        if (diff > ANG_HALF)
            delta = diff - ANG_MOD;
        else if (diff < -ANG_HALF)
            delta = diff + ANG_MOD;
        else
            delta = diff;
        acc_neg = -acc_reg;
        acc_mag = acc_reg[ACC_W-1] ? acc_neg[STEP_W-1:0] : acc_reg[STEP_W-1:0];
        divisor = (pps_reg == '0) ? ANGLE_BITS'(1) : pps_reg;
        interval_met = (now_reg - last_emit_reg) >= {{(TIME_W-IVAL_W){1'b0}}, min_ival_reg};
        rem_signed = $signed({{(ACC_W-ANGLE_BITS){1'b0}}, div_rem});
    end

    aesc_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == ST_START),
        .dividend  (acc_mag),
        .divisor   (divisor),
        .status    (div_st),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && enabled_reg)
                    state_next = ST_CALC;
            end
            ST_CALC: begin
                if (!have_base_reg || delta == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_START;
            end
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_st.done) begin
                    if (div_quo != '0 && interval_met)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            enabled_reg     <= 1'b0;
            zero_offset_reg <= '0;
            pps_reg         <= PPS_RESET;
            min_ival_reg    <= IVAL_RESET;
            last_pos_reg    <= '0;
            have_base_reg   <= 1'b0;
            acc_reg         <= '0;
            last_emit_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            // in emit the new beat takes over the output register
            if (m_valid_reg && m_ready && state_reg != ST_EMIT)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CALC: begin
                    if (!have_base_reg) begin
                        last_pos_reg  <= pos;
                        have_base_reg <= 1'b1;
                    end else if (delta != '0) begin
                        last_pos_reg <= pos;
                        acc_reg      <= acc_reg + delta;
                    end
                end
                ST_DIV: begin
                    if (div_st.done) begin
                        // truncation toward zero: remainder takes the dividend's sign
                        acc_reg <= acc_reg[ACC_W-1] ? -rem_signed : rem_signed;
                        if (div_quo != '0 && interval_met)
                            last_emit_reg <= now_reg;
                    end
                end
                ST_EMIT: begin
                    if (out_free)
                        m_valid_reg <= 1'b1;
                end
                default: ;
            endcase

            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ENABLED: begin
                        if (cfg_wdata[0] && !enabled_reg) begin
                            have_base_reg <= 1'b0;
                            acc_reg       <= '0;
                            last_emit_reg <= '0;
                        end
                        enabled_reg <= cfg_wdata[0];
                    end
                    CFG_ZERO_OFFSET:  zero_offset_reg <= cfg_wdata[ANGLE_BITS-1:0];
                    CFG_POS_PER_STEP: pps_reg         <= cfg_wdata[ANGLE_BITS-1:0];
                    CFG_MIN_INTERVAL: min_ival_reg    <= cfg_wdata[IVAL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            raw_reg <= s_raw_angle;
            now_reg <= s_now_ms;
        end
        if (state_reg == ST_DIV && div_st.done) begin
            res_dir_reg <= acc_reg[ACC_W-1];
            res_cnt_reg <= div_quo;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_dir_reg <= res_dir_reg;
            m_cnt_reg <= res_cnt_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_direction  = m_dir_reg;
    assign m_step_count = m_cnt_reg;

    // divider only runs on behalf of the sequencer
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // leftover movement never reaches a whole step of the largest size
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (acc_reg > -ANG_MOD && acc_reg < ANG_MOD))
        else $error("accumulator out of range while idle");

    // a new result always carries at least one step
    a_nonzero_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_step_count != '0)
        else $error("result with zero steps");

    // an accepted beat leaves idle only toward the delta stage
    a_accept_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == ST_IDLE || state_reg == ST_CALC))
        else $error("unexpected state after input beat");

endmodule

// ===== src/aesc_divider.sv =====
module aesc_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [aesc_pkg::STEP_W-1:0]     dividend,
    input  logic [aesc_pkg::ANGLE_BITS-1:0] divisor,
    output aesc_pkg::div_status_t           status,
    output logic [aesc_pkg::STEP_W-1:0]     quotient,
    output logic [aesc_pkg::ANGLE_BITS-1:0] remainder
);
    import aesc_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic [STEP_W-1:0]     quo_reg;
    logic [ANGLE_BITS-1:0] rem_reg;
    logic [ANGLE_BITS-1:0] dvs_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [ANGLE_BITS:0]   trial;
    logic                  fits;
    logic [ANGLE_BITS:0]   diff;

    always_comb begin
        trial = {rem_reg, quo_reg[STEP_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(STEP_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[STEP_W-2:0], fits};
            rem_reg <= fits ? diff[ANGLE_BITS-1:0] : trial[ANGLE_BITS-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule
